@@ src/bthf_pkg.sv @@
// Shared types and constants for the bus transaction handshake controller.
`default_nettype none

package bthf_pkg;

	localparam int unsigned THRESH_W      = 8;
	localparam int unsigned PAUSE_RESET   = 64;
	localparam int unsigned APB_DATA_W    = 32;
	localparam int unsigned APB_ADDR_W    = 3;
	localparam int unsigned TDATA_IN_W    = 8;
	localparam int unsigned TDATA_OUT_W   = 8;

	typedef enum logic {
		REG_PAUSE_THRESHOLD = 1'b0,
		REG_WAIT_STATE      = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic chipset_ready;
		logic fail_level;
		logic burst_last;
		logic data_enable;
	} in_item_t;

	typedef struct packed {
		logic pausing;
		logic checksum_failed;
		logic boot_ok;
		logic ready_pulse;
		logic burst_next;
		logic serve_req;
		logic bus_busy;
	} out_item_t;

	typedef struct packed {
		logic [THRESH_W-1:0] pause_threshold;
		logic                wait_state_enable;
	} cfg_t;

endpackage

`default_nettype wire

@@ src/bthf_cfg.sv @@
// Configuration register file with an APB-style access port.
`default_nettype none

module bthf_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [bthf_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [bthf_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [bthf_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                  pready,
	output bthf_pkg::cfg_t                        cfg
);
	import bthf_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pause_threshold   <= THRESH_W'(PAUSE_RESET);
			cfg_q.wait_state_enable <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_PAUSE_THRESHOLD: cfg_q.pause_threshold <= pwdata[THRESH_W-1:0];
				REG_WAIT_STATE:      cfg_q.wait_state_enable <= pwdata[0];
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PAUSE_THRESHOLD: prdata = APB_DATA_W'(cfg_q.pause_threshold);
			REG_WAIT_STATE:      prdata = APB_DATA_W'(cfg_q.wait_state_enable);
			default:             prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ src/bthf_core.sv @@
// Handshake state machine: one state update and one result per clock tick item.
`default_nettype none

module bthf_core #(
	parameter int unsigned COUNT_WIDTH = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire bthf_pkg::in_item_t   item,
	input  wire bthf_pkg::cfg_t       cfg,
	output bthf_pkg::out_item_t       result
);
	import bthf_pkg::*;

	localparam int unsigned CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;

	typedef enum logic [3:0] {
		PH_BOOT_HIGH  = 4'd0,
		PH_BOOT_LOW   = 4'd1,
		PH_IDLE       = 4'd2,
		PH_PAUSE      = 4'd3,
		PH_WAIT_READY = 4'd4,
		PH_PULSE      = 4'd5,
		PH_WAIT_CLEAR = 4'd6,
		PH_NEXT_WORD  = 4'd7,
		PH_HALT       = 4'd8
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic                   fail_prev_q;
	logic                   last_q, last_d;
	logic                   wait_q, wait_d;
	logic                   pulse;
	logic                   running;
	logic                   over_thresh;

	assign running     = (phase_q != PH_BOOT_HIGH) && (phase_q != PH_BOOT_LOW) &&
	                     (phase_q != PH_HALT);
	assign over_thresh = (CMP_W'(count_q) >= CMP_W'(cfg.pause_threshold)) &&
	                     (count_q != '0);

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		last_d  = last_q;
		wait_d  = wait_q;
		pulse   = 1'b0;
		priority if (running && item.fail_level && !fail_prev_q) begin
			phase_d = PH_HALT;
			wait_d  = 1'b0;
		end else if (phase_q == PH_BOOT_HIGH) begin
			if (item.data_enable) begin
				phase_d = PH_IDLE;
			end else if (item.fail_level) begin
				phase_d = PH_BOOT_LOW;
			end
		end else if (phase_q == PH_BOOT_LOW) begin
			if (item.data_enable || !item.fail_level) begin
				phase_d = PH_IDLE;
			end
		end else if (phase_q == PH_HALT) begin
			phase_d = PH_HALT;
		end else if (wait_q) begin
			wait_d = 1'b0;
		end else begin
			unique case (phase_q)
				PH_PAUSE: begin
					if (count_q == '0) begin
						count_d = count_q + 1'b1;
						last_d  = item.burst_last;
						phase_d = PH_WAIT_READY;
					end else begin
						count_d = count_q - 1'b1;
					end
				end
				PH_WAIT_READY: begin
					if (item.chipset_ready) begin
						phase_d = PH_PULSE;
						wait_d  = cfg.wait_state_enable;
					end
				end
				PH_PULSE: begin
					pulse   = 1'b1;
					phase_d = PH_WAIT_CLEAR;
				end
				PH_WAIT_CLEAR: begin
					if (!item.chipset_ready) begin
						phase_d = last_q ? PH_IDLE : PH_NEXT_WORD;
						wait_d  = cfg.wait_state_enable;
					end
				end
				PH_NEXT_WORD: begin
					count_d = count_q + 1'b1;
					last_d  = item.burst_last;
					phase_d = PH_WAIT_READY;
				end
				default: begin
					phase_d = PH_IDLE;
					if (item.data_enable) begin
						if (over_thresh) begin
							phase_d = PH_PAUSE;
						end else begin
							count_d = count_q + 1'b1;
							last_d  = item.burst_last;
							phase_d = PH_WAIT_READY;
						end
					end
				end
			endcase
		end
	end

	always_comb begin
		result             = '0;
		result.ready_pulse = pulse;
		unique case (phase_d)
			PH_HALT: begin
				result.checksum_failed = 1'b1;
			end
			PH_BOOT_HIGH, PH_BOOT_LOW: begin
				result.boot_ok = 1'b0;
			end
			PH_WAIT_READY: begin
				result.boot_ok   = 1'b1;
				result.bus_busy  = 1'b1;
				result.serve_req = 1'b1;
			end
			PH_PULSE: begin
				result.boot_ok  = 1'b1;
				result.bus_busy = !last_d;
			end
			PH_WAIT_CLEAR: begin
				result.boot_ok    = 1'b1;
				result.bus_busy   = !last_d;
				result.burst_next = !last_d;
			end
			PH_NEXT_WORD: begin
				result.boot_ok  = 1'b1;
				result.bus_busy = 1'b1;
			end
			PH_PAUSE: begin
				result.boot_ok = 1'b1;
				result.pausing = 1'b1;
			end
			default: begin
				result.boot_ok = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_BOOT_HIGH;
			count_q     <= '0;
			fail_prev_q <= 1'b0;
			last_q      <= 1'b0;
			wait_q      <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			count_q     <= count_d;
			fail_prev_q <= item.fail_level;
			last_q      <= last_d;
			wait_q      <= wait_d;
		end
	end

endmodule

`default_nettype wire

@@ src/bus_transaction_handshake_fsm_top.sv @@
// Top level of the bus transaction handshake controller with stream and APB ports.
// Pipeline: a transfer is registered in the input stage, its result in the output stage.
// Throughput: one transfer per cycle unless m_tready stalls the output; each tick's result
// depends only on its input and the previous tick's state, so each step is combinational.
// Reset: arst_n clears the input and result stages and puts the controller in the
// boot phase waiting for fail high, with the pause threshold at 64 and no wait states.
`default_nettype none

module bus_transaction_handshake_fsm_top #(
	parameter int unsigned COUNT_WIDTH = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [bthf_pkg::TDATA_IN_W-1:0]    s_tdata,  // data_enable, fail_level, chipset_ready
	input  wire logic                               s_tlast,  // burst_last
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [bthf_pkg::TDATA_OUT_W-1:0]   m_tdata,  // bus_busy, serve_req,
	                                                          // burst_next, ready_pulse,
	                                                          // boot_ok,
	                                                          // checksum_failed, pausing
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [bthf_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [bthf_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [bthf_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                    pready
);
	import bthf_pkg::*;

	cfg_t      cfg;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      advance;
	out_item_t result;
	logic      out_valid_q;
	out_item_t result_q;

	assign advance  = valid_s1 & (!out_valid_q | m_tready);
	assign s_tready = !valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.data_enable   <= s_tdata[0];
			item_s1.burst_last    <= s_tlast;
			item_s1.fail_level    <= s_tdata[1];
			item_s1.chipset_ready <= s_tdata[2];
		end
	end

	bthf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bthf_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_OUT_W'(result_q);

	a_no_drop_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("Held input transfer was lost.");

	a_cycle_in_tx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.serve_req |-> result_q.bus_busy &&
		result_q.boot_ok && !result_q.checksum_failed)
		else $error("Serve request without an active transaction.");

	a_pulse_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.ready_pulse |-> !result_q.serve_req && !result_q.pausing)
		else $error("Ready pulse overlaps another phase.");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		advance && $past(advance) && $past(result.checksum_failed) |->
		result.checksum_failed)
		else $error("Controller left the halted state.");

endmodule

`default_nettype wire
